FILE: sv/efr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths, codes and types for the elliptical foveation rate map.
// No dependencies; every other file in sv/ refers to it by scoped names.
package efr_pkg;

	localparam int TILE_SIZE  = 16;

	// Field widths
	localparam int SIZE_W     = 15;
	localparam int CENTER_W   = 16;
	localparam int PCT_W      = 7;
	localparam int SCALE_W    = 10;
	localparam int RATES_W    = 24;
	localparam int TILE_W     = 13;
	localparam int RATE_W     = 8;
	localparam int BAND_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Map height in tiles and the center tile
	localparam int HR_W   = SIZE_W + 1;
	localparam int HT_MAX = ((2 ** SIZE_W) - 1 + TILE_SIZE - 1) / TILE_SIZE;
	localparam int HT_W   = $clog2(HT_MAX + 1);
	localparam int CT_MAX = ((2 ** (CENTER_W - 1)) - 1) / TILE_SIZE;
	localparam int CT_W   = $clog2(CT_MAX + 1);

	// Semi-axes: b = (h_tiles * pct) / 200, a = (scale * b) / 100
	localparam int PB_W  = HT_W + PCT_W;
	localparam int QB_W  = PB_W - 3;
	localparam int B_MAX = HT_MAX * ((2 ** PCT_W) - 1) / 200;
	localparam int B_W   = $clog2(B_MAX + 1);
	localparam int XB_W  = SCALE_W + B_W;
	localparam int QA_W  = XB_W - 2;
	localparam int A_MAX = ((2 ** SCALE_W) - 1) * B_MAX / 100;
	localparam int A_W   = $clog2(A_MAX + 1);

	// floor(q / 25) = (q * DIV25_MUL) >> DIV25_SHIFT, exact for q < 2^28 / 19
	localparam int DIV25_SHIFT = 28;
	localparam int DIV25_MUL   = 10737419;
	localparam int DIV25_W     = 24;
	localparam int QBM_W       = QB_W + DIV25_W;
	localparam int QAM_W       = QA_W + DIV25_W;

	// Ellipse test: (dx*b)^2 + (dy*a)^2 < (a*b)^2
	localparam int DX_W   = (TILE_W > CT_W) ? TILE_W : CT_W;
	localparam int DXB_W  = DX_W + B_W;
	localparam int DYA_W  = DX_W + A_W;
	localparam int AB_W   = A_W + B_W;
	localparam int DXB2_W = 2 * DXB_W;
	localparam int DYA2_W = 2 * DYA_W;
	localparam int AB2_W  = 2 * AB_W;
	localparam int SUM_W  = ((DXB2_W > DYA2_W) ? DXB2_W : DYA2_W) + 1;
	localparam int CMP_W  = (SUM_W > AB2_W) ? SUM_W : AB2_W;

	// Accepting edge to the edge that takes the result
	localparam int LATENCY = 8;

	typedef logic [HR_W-1:0]   hr_t;
	typedef logic [HT_W-1:0]   ht_t;
	typedef logic [CT_W-1:0]   ct_t;
	typedef logic [PB_W-1:0]   pb_t;
	typedef logic [QBM_W-1:0]  qbm_t;
	typedef logic [B_W-1:0]    b_t;
	typedef logic [XB_W-1:0]   xb_t;
	typedef logic [QAM_W-1:0]  qam_t;
	typedef logic [A_W-1:0]    a_t;
	typedef logic [DX_W-1:0]   dx_t;
	typedef logic [DXB_W-1:0]  dxb_t;
	typedef logic [DYA_W-1:0]  dya_t;
	typedef logic [AB_W-1:0]   ab_t;
	typedef logic [DXB2_W-1:0] dxb2_t;
	typedef logic [DYA2_W-1:0] dya2_t;
	typedef logic [AB2_W-1:0]  ab2_t;
	typedef logic [CMP_W-1:0]  cmp_t;

	// Band codes
	localparam logic [BAND_W-1:0] BAND_INNER  = 2'd0;
	localparam logic [BAND_W-1:0] BAND_MIDDLE = 2'd1;
	localparam logic [BAND_W-1:0] BAND_OUTER  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_VALUES   = 3'd7;

	// Reset values
	localparam logic [SIZE_W-1:0]   RST_TARGET_WIDTH  = 15'd2048;
	localparam logic [SIZE_W-1:0]   RST_TARGET_HEIGHT = 15'd2048;
	localparam logic [CENTER_W-1:0] RST_CENTER_X      = 16'd1024;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y      = 16'd1024;
	localparam logic [PCT_W-1:0]    RST_INNER_RADIUS  = 7'd50;
	localparam logic [PCT_W-1:0]    RST_OUTER_RADIUS  = 7'd60;
	localparam logic [SCALE_W-1:0]  RST_X_SCALE       = 10'd100;
	localparam logic [RATES_W-1:0]  RST_RATE_VALUES   = 24'h020100;

	typedef struct packed {
		logic [SIZE_W-1:0]   target_width;
		logic [SIZE_W-1:0]   target_height;
		logic [CENTER_W-1:0] center_x_px;
		logic [CENTER_W-1:0] center_y_px;
		logic [PCT_W-1:0]    inner_radius_pct;
		logic [PCT_W-1:0]    outer_radius_pct;
		logic [SCALE_W-1:0]  x_scale_pct;
		logic [RATES_W-1:0]  rate_values;
	} cfg_t;

	typedef struct packed {
		a_t a;
		b_t b;
	} axes_t;

endpackage

FILE: sv/efr_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the foveation rate map.
// Depends on efr_pkg for widths, register indexes and reset values.
module efr_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [efr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [efr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output efr_pkg::cfg_t                     cfg
);

	efr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_width     <= efr_pkg::RST_TARGET_WIDTH;
			cfg_q.target_height    <= efr_pkg::RST_TARGET_HEIGHT;
			cfg_q.center_x_px      <= efr_pkg::RST_CENTER_X;
			cfg_q.center_y_px      <= efr_pkg::RST_CENTER_Y;
			cfg_q.inner_radius_pct <= efr_pkg::RST_INNER_RADIUS;
			cfg_q.outer_radius_pct <= efr_pkg::RST_OUTER_RADIUS;
			cfg_q.x_scale_pct      <= efr_pkg::RST_X_SCALE;
			cfg_q.rate_values      <= efr_pkg::RST_RATE_VALUES;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				efr_pkg::REG_TARGET_WIDTH: begin
					cfg_q.target_width <= cfg_data[efr_pkg::SIZE_W-1:0];
				end
				efr_pkg::REG_TARGET_HEIGHT: begin
					cfg_q.target_height <= cfg_data[efr_pkg::SIZE_W-1:0];
				end
				efr_pkg::REG_CENTER_X: begin
					cfg_q.center_x_px <= cfg_data[efr_pkg::CENTER_W-1:0];
				end
				efr_pkg::REG_CENTER_Y: begin
					cfg_q.center_y_px <= cfg_data[efr_pkg::CENTER_W-1:0];
				end
				efr_pkg::REG_INNER_RADIUS: begin
					cfg_q.inner_radius_pct <= cfg_data[efr_pkg::PCT_W-1:0];
				end
				efr_pkg::REG_OUTER_RADIUS: begin
					cfg_q.outer_radius_pct <= cfg_data[efr_pkg::PCT_W-1:0];
				end
				efr_pkg::REG_X_SCALE: begin
					cfg_q.x_scale_pct <= cfg_data[efr_pkg::SCALE_W-1:0];
				end
				efr_pkg::REG_RATE_VALUES: begin
					cfg_q.rate_values <= cfg_data[efr_pkg::RATES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/efr_axes.sv
`timescale 1ns / 1ps
// Semi-axis pipeline for one ellipse: five stages from configuration to (a, b).
// Depends on efr_pkg; runs in lockstep with the item pipeline of the top level.
module efr_axes (
	input  logic                          clk,
	input  logic [efr_pkg::SIZE_W-1:0]    target_height,
	input  logic [efr_pkg::PCT_W-1:0]     radius_pct,
	input  logic [efr_pkg::SCALE_W-1:0]   x_scale_pct,
	output efr_pkg::axes_t                axes
);

	efr_pkg::hr_t   h_round;
	efr_pkg::ht_t   h_tiles;
	efr_pkg::b_t    b_next;

	efr_pkg::pb_t   p_s1;
	efr_pkg::qbm_t  bq_s2;
	efr_pkg::b_t    b_s3;
	efr_pkg::xb_t   xb_s3;
	efr_pkg::b_t    b_s4;
	efr_pkg::qam_t  aq_s4;
	efr_pkg::axes_t axes_s5;

	// map height in tiles, rounded up
	assign h_round = efr_pkg::hr_t'(target_height) + efr_pkg::hr_t'(efr_pkg::TILE_SIZE - 1);
	assign h_tiles = efr_pkg::ht_t'(h_round / efr_pkg::TILE_SIZE);

	assign b_next = efr_pkg::b_t'(bq_s2 >> efr_pkg::DIV25_SHIFT);

	always_ff @(posedge clk) begin
		p_s1  <= efr_pkg::pb_t'(h_tiles) * efr_pkg::pb_t'(radius_pct);
		// /200 = >>3 then /25 by reciprocal
		bq_s2 <= efr_pkg::qbm_t'(p_s1[efr_pkg::PB_W-1:3]) * efr_pkg::qbm_t'(efr_pkg::DIV25_MUL);
		b_s3  <= b_next;
		xb_s3 <= efr_pkg::xb_t'(x_scale_pct) * efr_pkg::xb_t'(b_next);
		b_s4  <= b_s3;
		// /100 = >>2 then /25 by reciprocal
		aq_s4 <= efr_pkg::qam_t'(xb_s3[efr_pkg::XB_W-1:2]) * efr_pkg::qam_t'(efr_pkg::DIV25_MUL);
		axes_s5.a <= efr_pkg::a_t'(aq_s4 >> efr_pkg::DIV25_SHIFT);
		axes_s5.b <= b_s4;
	end

	assign axes = axes_s5;

endmodule

FILE: sv/efr_ellipse.sv
`timescale 1ns / 1ps
// Exact inside-ellipse test: (dx*b)^2 + (dy*a)^2 < (a*b)^2, two product stages.
// Depends on efr_pkg; the flag comes straight off the second stage registers.
module efr_ellipse (
	input  logic           clk,
	input  efr_pkg::dx_t   dx,
	input  efr_pkg::dx_t   dy,
	input  efr_pkg::axes_t axes,
	output logic           hit
);

	efr_pkg::dxb_t  dxb_s6;
	efr_pkg::dya_t  dya_s6;
	efr_pkg::ab_t   ab_s6;
	efr_pkg::dxb2_t dxb2_s7;
	efr_pkg::dya2_t dya2_s7;
	efr_pkg::ab2_t  ab2_s7;

	always_ff @(posedge clk) begin
		dxb_s6  <= efr_pkg::dxb_t'(dx) * efr_pkg::dxb_t'(axes.b);
		dya_s6  <= efr_pkg::dya_t'(dy) * efr_pkg::dya_t'(axes.a);
		ab_s6   <= efr_pkg::ab_t'(axes.a) * efr_pkg::ab_t'(axes.b);
		dxb2_s7 <= efr_pkg::dxb2_t'(dxb_s6) * efr_pkg::dxb2_t'(dxb_s6);
		dya2_s7 <= efr_pkg::dya2_t'(dya_s6) * efr_pkg::dya2_t'(dya_s6);
		ab2_s7  <= efr_pkg::ab2_t'(ab_s6) * efr_pkg::ab2_t'(ab_s6);
	end

	// a zero axis makes the right side zero, so the strict compare fails by itself
	assign hit = (efr_pkg::cmp_t'(dxb2_s7) + efr_pkg::cmp_t'(dya2_s7))
		< efr_pkg::cmp_t'(ab2_s7);

endmodule

FILE: sv/elliptical_foveation_rate_map.sv
`timescale 1ns / 1ps
// A result strobes on done once its item has passed the whole pipeline.
// Throughput: one item per cycle; busy stays low and done is high one cycle per item.
// The pipeline has eight stages: one reciprocal multiply per semi-axis, then
// the product and square stages of the ellipse test, then the band/rate register.
// Reset: arst_n clears the valid bits and restores the config; the receiver cannot stall.
// Depends on efr_pkg, efr_regs, efr_axes and efr_ellipse.
module elliptical_foveation_rate_map (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [efr_pkg::TILE_W-1:0]        tile_x,
	input  logic [efr_pkg::TILE_W-1:0]        tile_y,
	output logic                              done,
	output logic [efr_pkg::RATE_W-1:0]        rate,
	output logic [efr_pkg::BAND_W-1:0]        band,
	input  logic                              cfg_wr_en,
	input  logic [efr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [efr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	efr_pkg::cfg_t  cfg;
	efr_pkg::axes_t axes_inner;
	efr_pkg::axes_t axes_outer;

	logic accept;
	logic in_inner;
	logic in_outer;

	logic [efr_pkg::SIZE_W-1:0] cx_px;
	logic [efr_pkg::SIZE_W-1:0] cy_px;
	logic [efr_pkg::BAND_W-1:0] band_next;
	logic [efr_pkg::RATE_W-1:0] rate_next;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, done_s8;

	logic [efr_pkg::TILE_W-1:0] tx_s1;
	logic [efr_pkg::TILE_W-1:0] ty_s1;
	efr_pkg::ct_t cx_s1;
	efr_pkg::ct_t cy_s1;
	efr_pkg::dx_t dx_s2, dx_s3, dx_s4, dx_s5;
	efr_pkg::dx_t dy_s2, dy_s3, dy_s4, dy_s5;
	logic [efr_pkg::RATE_W-1:0] rate_s8;
	logic [efr_pkg::BAND_W-1:0] band_s8;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	efr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	efr_axes u_axes_inner (
		.clk           (clk),
		.target_height (cfg.target_height),
		.radius_pct    (cfg.inner_radius_pct),
		.x_scale_pct   (cfg.x_scale_pct),
		.axes          (axes_inner)
	);

	efr_axes u_axes_outer (
		.clk           (clk),
		.target_height (cfg.target_height),
		.radius_pct    (cfg.outer_radius_pct),
		.x_scale_pct   (cfg.x_scale_pct),
		.axes          (axes_outer)
	);

	efr_ellipse u_ell_inner (
		.clk  (clk),
		.dx   (dx_s5),
		.dy   (dy_s5),
		.axes (axes_inner),
		.hit  (in_inner)
	);

	efr_ellipse u_ell_outer (
		.clk  (clk),
		.dx   (dx_s5),
		.dy   (dy_s5),
		.axes (axes_outer),
		.hit  (in_outer)
	);

	// clamp the signed pixel center to [0, target size]
	always_comb begin
		if (cfg.center_x_px[efr_pkg::CENTER_W-1]) begin
			cx_px = '0;
		end else if (cfg.center_x_px[efr_pkg::CENTER_W-2:0] > cfg.target_width) begin
			cx_px = cfg.target_width;
		end else begin
			cx_px = cfg.center_x_px[efr_pkg::CENTER_W-2:0];
		end
		if (cfg.center_y_px[efr_pkg::CENTER_W-1]) begin
			cy_px = '0;
		end else if (cfg.center_y_px[efr_pkg::CENTER_W-2:0] > cfg.target_height) begin
			cy_px = cfg.target_height;
		end else begin
			cy_px = cfg.center_y_px[efr_pkg::CENTER_W-2:0];
		end
	end

	// inner test wins over outer
	always_comb begin
		if (in_inner) begin
			band_next = efr_pkg::BAND_INNER;
		end else if (in_outer) begin
			band_next = efr_pkg::BAND_MIDDLE;
		end else begin
			band_next = efr_pkg::BAND_OUTER;
		end
		case (band_next)
			efr_pkg::BAND_INNER: begin
				rate_next = cfg.rate_values[efr_pkg::RATE_W-1:0];
			end
			efr_pkg::BAND_MIDDLE: begin
				rate_next = cfg.rate_values[2*efr_pkg::RATE_W-1:efr_pkg::RATE_W];
			end
			default: begin
				rate_next = cfg.rate_values[3*efr_pkg::RATE_W-1:2*efr_pkg::RATE_W];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			done_s8 <= 1'b0;
		end else begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			done_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		tx_s1 <= tile_x;
		ty_s1 <= tile_y;
		cx_s1 <= efr_pkg::ct_t'(cx_px / efr_pkg::TILE_SIZE);
		cy_s1 <= efr_pkg::ct_t'(cy_px / efr_pkg::TILE_SIZE);

		dx_s2 <= (efr_pkg::dx_t'(tx_s1) > efr_pkg::dx_t'(cx_s1))
			? efr_pkg::dx_t'(tx_s1) - efr_pkg::dx_t'(cx_s1)
			: efr_pkg::dx_t'(cx_s1) - efr_pkg::dx_t'(tx_s1);
		dy_s2 <= (efr_pkg::dx_t'(ty_s1) > efr_pkg::dx_t'(cy_s1))
			? efr_pkg::dx_t'(ty_s1) - efr_pkg::dx_t'(cy_s1)
			: efr_pkg::dx_t'(cy_s1) - efr_pkg::dx_t'(ty_s1);

		// wait for the semi-axes
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		dx_s4 <= dx_s3;
		dy_s4 <= dy_s3;
		dx_s5 <= dx_s4;
		dy_s5 <= dy_s4;

		rate_s8 <= rate_next;
		band_s8 <= band_next;
	end

	assign done = done_s8;
	assign rate = rate_s8;
	assign band = band_s8;

endmodule

FILE: sv/efr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the foveation rate map, bound to the top level.
// Depends on efr_pkg for the pipeline latency.
module efr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [efr_pkg::TILE_W-1:0]        tile_x,
	input logic [efr_pkg::TILE_W-1:0]        tile_y,
	input logic                              done,
	input logic [efr_pkg::RATE_W-1:0]        rate,
	input logic [efr_pkg::BAND_W-1:0]        band
);

	// every accepted item gives a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(efr_pkg::LATENCY) done)
		else $error("accepted item produced no result");

	// no result without an item accepted the latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, efr_pkg::LATENCY))
		else $error("result without accepted item");

	// back-to-back results in one band carry one rate
	a_band_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && band == $past(band)) |-> rate == $past(rate))
		else $error("same band gave different rates");

	// the same tile twice in a row classifies the same
	a_repeat_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && $past(arst_n) && $past(start && !busy)
			&& tile_x == $past(tile_x) && tile_y == $past(tile_y))
		|-> ##(efr_pkg::LATENCY) (band == $past(band) && rate == $past(rate)))
		else $error("repeated tile gave a different result");

endmodule

bind elliptical_foveation_rate_map efr_checker u_efr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.tile_x (tile_x),
	.tile_y (tile_y),
	.done   (done),
	.rate   (rate),
	.band   (band)
);
